// ===== design/gtsl_pkg.sv =====
// Shared widths, register codes and the result side-band type for the greedy
// token selector with fixed-point log-softmax. No dependencies.
package gtsl_pkg;

    localparam int LOGIT_W     = 16;
    localparam int PENALTY_W   = 15;
    localparam int TOKEN_W     = 13;
    localparam int STREAM_W    = 8;
    localparam int FRAME_W     = 16;
    localparam int LOGP_W      = 15;
    localparam int SUM_W       = 30;
    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_BLANK_PENALTY = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNKNOWN_TOKEN = 8'd1;

    localparam logic [SUM_W-1:0] SUM_MAX     = '1;
    localparam logic [63:0]      ONE_Q30     = 64'd1 << 30;
    localparam int               LOGP_FLOOR  = 9300;

    // what travels with a finished row down the log pipeline
    typedef struct packed {
        logic [TOKEN_W-1:0]  token;
        logic                emitted;
        logic [STREAM_W-1:0] stream;
        logic [FRAME_W-1:0]  timestamp;
    } meta_t;

endpackage

// ===== design/gtsl_neglog.sv =====
// Pipelined -ln(sum / 2^16) in Q10 for the row sum of the log-softmax.
// Depends on gtsl_pkg (widths, meta_t, constants).
module gtsl_neglog (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [gtsl_pkg::SUM_W-1:0]          in_sum,
    input  gtsl_pkg::meta_t                     in_meta,
    output logic                                out_valid,
    output logic signed [gtsl_pkg::LOGP_W-1:0]  out_logp,
    output gtsl_pkg::meta_t                     out_meta
);

    localparam int DIV_STEPS = 30;
    localparam int TERMS     = 20;
    localparam logic [63:0] THIRD_Q30 = gtsl_pkg::ONE_Q30 / 3;

    // 2*atanh(z) in Q30, used at elaboration for the ln 2 constant
    function automatic logic [63:0] atanh2_const(input logic [63:0] z);
        logic [63:0] z2;
        logic [63:0] p;
        logic [63:0] acc;
        z2  = (z * z) >> 30;
        p   = z;
        acc = 64'd0;
        for (int k = 1; k <= 39; k += 2) begin
            acc = acc + p / 64'(k);
            p   = (p * z2) >> 30;
        end
        return acc << 1;
    endfunction

    localparam logic [63:0] LN2_Q30 = atanh2_const(THIRD_Q30);

    // leading-one stage
    logic                        d_valid_reg;
    logic [gtsl_pkg::SUM_W-1:0]  d_sum_reg;
    logic [4:0]                  d_k_reg;
    gtsl_pkg::meta_t             d_meta_reg;

    logic [gtsl_pkg::SUM_W-1:0]  sum_cl;
    logic [4:0]                  k_next;

    always_comb begin
        sum_cl = (in_sum < 30'd65536) ? 30'd65536 : in_sum;
        k_next = 5'd0;
        for (int b = 0; b < gtsl_pkg::SUM_W; b++) begin
            if (sum_cl[b]) k_next = 5'(b);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_sum_reg  <= sum_cl;
            d_k_reg    <= k_next;
            d_meta_reg <= in_meta;
        end
    end

    // restoring divider, one quotient bit a stage: z = (m-1)/(m+1) in Q30
    logic                   div_valid_reg [DIV_STEPS+1];
    logic [31:0]            div_rem_reg   [DIV_STEPS+1];
    logic [31:0]            div_den_reg   [DIV_STEPS+1];
    logic [29:0]            div_quo_reg   [DIV_STEPS+1];
    logic [4:0]             div_k_reg     [DIV_STEPS+1];
    gtsl_pkg::meta_t        div_meta_reg  [DIV_STEPS+1];

    logic [31:0] mant;
    assign mant = 32'(d_sum_reg) << (5'd30 - d_k_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_valid_reg[0] <= 1'b0;
        end else if (en) begin
            div_valid_reg[0] <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            div_rem_reg[0]  <= {2'b00, mant[29:0]};
            div_den_reg[0]  <= mant + 32'(gtsl_pkg::ONE_Q30);
            div_quo_reg[0]  <= 30'd0;
            div_k_reg[0]    <= d_k_reg;
            div_meta_reg[0] <= d_meta_reg;
        end
    end

    for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
        logic [32:0] rem2;
        logic        ge;
        assign rem2 = {div_rem_reg[j-1], 1'b0};
        assign ge   = rem2 >= {1'b0, div_den_reg[j-1]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                div_valid_reg[j] <= 1'b0;
            end else if (en) begin
                div_valid_reg[j] <= div_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                div_rem_reg[j]  <= ge ? 32'(rem2 - {1'b0, div_den_reg[j-1]}) : rem2[31:0];
                div_den_reg[j]  <= div_den_reg[j-1];
                div_quo_reg[j]  <= {div_quo_reg[j-1][28:0], ge};
                div_k_reg[j]    <= div_k_reg[j-1];
                div_meta_reg[j] <= div_meta_reg[j-1];
            end
        end
    end

    // atanh series: stage 0 squares z, stage j takes p/(2j-1), adds the prior term and steps p
    logic             ser_valid_reg [TERMS+1];
    logic [29:0]      ser_p_reg     [TERMS+1];
    logic [29:0]      ser_z2_reg    [TERMS+1];
    logic [29:0]      ser_trm_reg   [TERMS+1];
    logic [31:0]      ser_acc_reg   [TERMS+1];
    logic [4:0]       ser_k_reg     [TERMS+1];
    gtsl_pkg::meta_t  ser_meta_reg  [TERMS+1];

    logic [63:0] zsq;
    assign zsq = 64'(div_quo_reg[DIV_STEPS]) * 64'(div_quo_reg[DIV_STEPS]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_valid_reg[0] <= 1'b0;
        end else if (en) begin
            ser_valid_reg[0] <= div_valid_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ser_p_reg[0]    <= div_quo_reg[DIV_STEPS];
            ser_z2_reg[0]   <= zsq[59:30];
            ser_trm_reg[0]  <= 30'd0;
            ser_acc_reg[0]  <= 32'd0;
            ser_k_reg[0]    <= div_k_reg[DIV_STEPS];
            ser_meta_reg[0] <= div_meta_reg[DIV_STEPS];
        end
    end

    for (genvar j = 1; j <= TERMS; j++) begin : g_ser
        localparam int K = 2 * j - 1;
        localparam int L = $clog2(K);
        // floor(p/K) = (p*RECIP) >> (30+L) for every p below 2^30
        localparam logic [63:0] RECIP = ((64'd1 << (30 + L)) / 64'(K)) + 64'd1;

        logic [63:0] quot_prod;
        logic [63:0] step_prod;
        assign quot_prod = 64'(ser_p_reg[j-1]) * RECIP;
        assign step_prod = 64'(ser_p_reg[j-1]) * 64'(ser_z2_reg[j-1]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                ser_valid_reg[j] <= 1'b0;
            end else if (en) begin
                ser_valid_reg[j] <= ser_valid_reg[j-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                ser_trm_reg[j]  <= 30'(quot_prod >> (30 + L));
                ser_p_reg[j]    <= 30'(step_prod >> 30);
                ser_acc_reg[j]  <= ser_acc_reg[j-1] + 32'(ser_trm_reg[j-1]);
                ser_z2_reg[j]   <= ser_z2_reg[j-1];
                ser_k_reg[j]    <= ser_k_reg[j-1];
                ser_meta_reg[j] <= ser_meta_reg[j-1];
            end
        end
    end

    // ln in Q30 = (k-16)*ln2 + 2*atanh(z)
    logic             f_valid_reg;
    logic [39:0]      f_ln_reg;
    gtsl_pkg::meta_t  f_meta_reg;

    logic [32:0] atan_sum;
    logic [3:0]  exp_sh;
    assign atan_sum = 33'(ser_acc_reg[TERMS]) + 33'(ser_trm_reg[TERMS]);
    assign exp_sh   = 4'(ser_k_reg[TERMS] - 5'd16);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= ser_valid_reg[TERMS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_ln_reg   <= (40'(atan_sum) << 1) + 40'(exp_sh) * 40'(LN2_Q30);
            f_meta_reg <= ser_meta_reg[TERMS];
        end
    end

    // round half up to Q10, floor, negate
    logic [39:0]               ln_rnd;
    logic [19:0]               q_raw;
    logic [gtsl_pkg::LOGP_W-1:0] q_cl;
    assign ln_rnd = f_ln_reg + 40'(1 << 19);
    assign q_raw  = ln_rnd[39:20];
    assign q_cl   = (q_raw > 20'(gtsl_pkg::LOGP_FLOOR)) ? 15'(gtsl_pkg::LOGP_FLOOR)
                                                         : q_raw[14:0];

    logic                                 o_valid_reg;
    logic signed [gtsl_pkg::LOGP_W-1:0]   o_logp_reg;
    gtsl_pkg::meta_t                      o_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_logp_reg <= $signed(15'd0 - q_cl);
            o_meta_reg <= f_meta_reg;
        end
    end

    assign out_valid = o_valid_reg;
    assign out_logp  = o_logp_reg;
    assign out_meta  = o_meta_reg;

endmodule

// ===== design/greedy_token_select_logsoftmax_top.sv =====
// Top level of the greedy token selector: online arg-max and log-sum-exp over
// each row of logits, then the pipelined log unit. Depends on gtsl_pkg, gtsl_neglog.
//
// Usage: logits arrive one item per cycle on the s_ channel (valid/ready);
// s_row_last marks the last logit of a stream's row. Position zero of a row
// has blank_penalty taken off. One result leaves on the m_ channel per row:
// first arg-max token, emitted flag, log-probability in Q5.10, and the
// stream and frame of the row's last item.
// Throughput: one item per cycle while s_ready is high, rows of any length back to back.
// Path: the result of a row passes the input, table and sum registers, the
// 30-step restoring divider and the 20-term atanh series of the log pipeline
// and the output register before it shows on m_valid.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 blank_penalty,
// 1 unknown_token) and cfg_data; always ready, write only while idle.
// Reset (aresetn low, synchronous) clears the row state, all pipeline valid
// bits and sets the registers to 0 and 2.
// Stall: the output register plus a skid register absorb a stalled m_ready;
// s_ready drops only once the skid register is full, and the whole
// pipeline then holds until the receiver takes the waiting result.
module greedy_token_select_logsoftmax_top #(
    parameter int MAX_VOCAB       = 8192,
    parameter int EXP_TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gtsl_pkg::LOGIT_W-1:0]  s_logit,
    input  logic                                 s_row_last,
    input  logic [gtsl_pkg::STREAM_W-1:0]        s_stream_index,
    input  logic [gtsl_pkg::FRAME_W-1:0]         s_frame_index,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [gtsl_pkg::TOKEN_W-1:0]         m_token,
    output logic                                 m_emitted,
    output logic signed [gtsl_pkg::LOGP_W-1:0]   m_log_probability,
    output logic [gtsl_pkg::STREAM_W-1:0]        m_out_stream,
    output logic [gtsl_pkg::FRAME_W-1:0]         m_timestamp,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gtsl_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [gtsl_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int POS_W = $clog2(MAX_VOCAB);
    localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_VOCAB - 1);
    localparam logic signed [15:0] MAX_RESET = 16'sh8000;

    // exp(-f) in Q30 for f in [0,1], series form
    function automatic logic [63:0] exp_neg_frac(input logic [63:0] f);
        logic [63:0]        term;
        logic signed [63:0] acc;
        term = gtsl_pkg::ONE_Q30;
        acc  = $signed(gtsl_pkg::ONE_Q30);
        for (int k = 1; k <= 24; k++) begin
            term = ((term * f) >> 30) / 64'(k);
            if (k % 2 == 1) acc = acc - $signed(term);
            else            acc = acc + $signed(term);
        end
        if (acc < 0) acc = 64'sd0;
        return $unsigned(acc);
    endfunction

    // entry i: exp(-16*i/depth) in Q16, rounded
    function automatic logic [16:0] exp_entry(input int i);
        logic [63:0] x;
        logic [63:0] whole;
        logic [63:0] e1;
        logic [63:0] v;
        x     = (64'(i) << 34) / 64'(EXP_TABLE_DEPTH);
        whole = x >> 30;
        e1    = exp_neg_frac(gtsl_pkg::ONE_Q30);
        v     = exp_neg_frac(x & (gtsl_pkg::ONE_Q30 - 64'd1));
        for (int n = 0; n < 16; n++) begin
            if (64'(n) < whole) v = (v * e1) >> 30;
        end
        return 17'((v + 64'd8192) >> 14);
    endfunction

    logic [16:0] exp_rom [EXP_TABLE_DEPTH];
    for (genvar gi = 0; gi < EXP_TABLE_DEPTH; gi++) begin : g_rom
        localparam logic [16:0] ENTRY = exp_entry(gi);
        assign exp_rom[gi] = ENTRY;
    end

    // configuration
    logic [gtsl_pkg::PENALTY_W-1:0] penalty_reg;
    logic [gtsl_pkg::TOKEN_W-1:0]   unknown_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            penalty_reg <= '0;
            unknown_reg <= 13'd2;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                gtsl_pkg::CFG_BLANK_PENALTY: penalty_reg <= cfg_data;
                gtsl_pkg::CFG_UNKNOWN_TOKEN: unknown_reg <= cfg_data[12:0];
                default: ;
            endcase
        end
    end

    logic pipe_en;
    logic skid_valid_reg;
    assign pipe_en = !skid_valid_reg;
    assign s_ready = pipe_en;

    // input register
    logic                                a_valid_reg;
    logic signed [gtsl_pkg::LOGIT_W-1:0] a_logit_reg;
    logic                                a_last_reg;
    logic [gtsl_pkg::STREAM_W-1:0]       a_stream_reg;
    logic [gtsl_pkg::FRAME_W-1:0]        a_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            a_logit_reg  <= s_logit;
            a_last_reg   <= s_row_last;
            a_stream_reg <= s_stream_index;
            a_frame_reg  <= s_frame_index;
        end
    end

    // running max, arg-max and position; table address
    logic signed [15:0] running_max_reg;
    logic [POS_W-1:0]   position_reg;
    logic [POS_W-1:0]   best_index_reg;

    logic signed [17:0] v_wide;
    logic signed [15:0] v_adj;
    logic signed [16:0] v_delta;
    logic [16:0]        diff;
    logic               gt;
    logic               far;
    logic [31:0]        scaled;
    logic [IDX_W-1:0]   rom_idx;

    always_comb begin
        v_wide = 18'(a_logit_reg);
        if (position_reg == '0) begin
            v_wide = v_wide - $signed({3'b000, penalty_reg});
        end
        v_adj   = (v_wide < -18'sd32768) ? MAX_RESET : v_wide[15:0];
        gt      = v_adj > running_max_reg;
        v_delta = 17'(v_adj) - 17'(running_max_reg);
        diff    = gt ? $unsigned(v_delta) : $unsigned(17'sd0 - v_delta);
        far     = |diff[16:14];
        scaled  = 32'(diff[13:0]) * 32'(EXP_TABLE_DEPTH);
        rom_idx = scaled[14 +: IDX_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_max_reg <= MAX_RESET;
            position_reg    <= '0;
            best_index_reg  <= '0;
        end else if (pipe_en && a_valid_reg) begin
            if (a_last_reg) begin
                running_max_reg <= MAX_RESET;
                position_reg    <= '0;
                best_index_reg  <= '0;
            end else begin
                if (gt) begin
                    running_max_reg <= v_adj;
                    best_index_reg  <= position_reg;
                end
                if (position_reg != POS_LAST) position_reg <= position_reg + 1'b1;
            end
        end
    end

    logic                          b_valid_reg;
    logic                          b_gt_reg;
    logic                          b_far_reg;
    logic                          b_last_reg;
    logic [16:0]                   b_exp_reg;
    logic [POS_W-1:0]              b_best_reg;
    logic [gtsl_pkg::STREAM_W-1:0] b_stream_reg;
    logic [gtsl_pkg::FRAME_W-1:0]  b_frame_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            b_exp_reg    <= exp_rom[rom_idx];
            b_gt_reg     <= gt;
            b_far_reg    <= far;
            b_last_reg   <= a_last_reg;
            b_best_reg   <= gt ? position_reg : best_index_reg;
            b_stream_reg <= a_stream_reg;
            b_frame_reg  <= a_frame_reg;
        end
    end

    // rescaled running sum in Q14.16
    logic [gtsl_pkg::SUM_W-1:0] running_sum_reg;
    logic [16:0]                term;
    logic [47:0]                prod;
    logic [31:0]                sum_up;
    logic [31:0]                sum_add;
    logic [31:0]                sum_raw;
    logic [gtsl_pkg::SUM_W-1:0] sum_sat;

    always_comb begin
        term    = b_far_reg ? 17'd0 : b_exp_reg;
        prod    = 48'(running_sum_reg) * 48'(term) + 48'd32768;
        sum_up  = 32'(prod[47:16]) + 32'd65536;
        sum_add = 32'(running_sum_reg) + 32'(term);
        sum_raw = b_gt_reg ? sum_up : sum_add;
        sum_sat = (sum_raw > 32'(gtsl_pkg::SUM_MAX)) ? gtsl_pkg::SUM_MAX : sum_raw[29:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_sum_reg <= '0;
        end else if (pipe_en && b_valid_reg) begin
            running_sum_reg <= b_last_reg ? '0 : sum_sat;
        end
    end

    logic                       c_valid_reg;
    logic [gtsl_pkg::SUM_W-1:0] c_sum_reg;
    gtsl_pkg::meta_t            c_meta_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            c_valid_reg <= b_valid_reg && b_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            c_sum_reg            <= sum_sat;
            c_meta_reg.token     <= gtsl_pkg::TOKEN_W'(b_best_reg);
            c_meta_reg.emitted   <= (b_best_reg != '0) &&
                                    (32'(b_best_reg) != 32'(unknown_reg));
            c_meta_reg.stream    <= b_stream_reg;
            c_meta_reg.timestamp <= b_frame_reg;
        end
    end

    logic                                log_valid;
    logic signed [gtsl_pkg::LOGP_W-1:0]  log_logp;
    gtsl_pkg::meta_t                     log_meta;

    gtsl_neglog u_neglog (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (c_valid_reg),
        .in_sum    (c_sum_reg),
        .in_meta   (c_meta_reg),
        .out_valid (log_valid),
        .out_logp  (log_logp),
        .out_meta  (log_meta)
    );

    // output register with skid register behind it
    logic                                m_valid_reg;
    logic signed [gtsl_pkg::LOGP_W-1:0]  m_logp_reg;
    gtsl_pkg::meta_t                     m_meta_reg;
    logic signed [gtsl_pkg::LOGP_W-1:0]  skid_logp_reg;
    gtsl_pkg::meta_t                     skid_meta_reg;
    logic                                m_free;

    assign m_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) skid_valid_reg <= 1'b0;
        end else if (log_valid && m_free) begin
            m_valid_reg <= 1'b1;
        end else if (log_valid) begin
            skid_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                m_logp_reg <= skid_logp_reg;
                m_meta_reg <= skid_meta_reg;
            end
        end else if (log_valid && m_free) begin
            m_logp_reg <= log_logp;
            m_meta_reg <= log_meta;
        end else if (log_valid) begin
            skid_logp_reg <= log_logp;
            skid_meta_reg <= log_meta;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_token           = m_meta_reg.token;
    assign m_emitted         = m_meta_reg.emitted;
    assign m_log_probability = m_logp_reg;
    assign m_out_stream      = m_meta_reg.stream;
    assign m_timestamp       = m_meta_reg.timestamp;

    // skid only ever holds an item behind a waiting output item
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid register full with output register empty");

    // row end clears the arg-max state
    a_row_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && a_valid_reg && a_last_reg) |=>
            (position_reg == '0) && (best_index_reg == '0) &&
            (running_max_reg == MAX_RESET))
        else $error("row state not cleared after row end");

    // row end clears the running sum
    a_sum_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (pipe_en && b_valid_reg && b_last_reg) |=> (running_sum_reg == '0))
        else $error("running sum not cleared after row end");

    // a result arriving at a busy output lands in the skid register
    a_skid_catch: assert property (@(posedge aclk) disable iff (!aresetn)
        (log_valid && m_valid_reg && !m_ready && !skid_valid_reg) |=> skid_valid_reg)
        else $error("result lost at stalled output");

endmodule
